>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds at every clock edge out of reset.
`define SVDD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("svdd assertion failed");
// Assert that an antecedent is followed by a consequent in the next cycle.
`define SVDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svdd assertion failed");
`endif

>>> src/svdd_pkg.sv
// Types and constants of the stream vbyte delta decoder.
package svdd_pkg;

  typedef enum logic [2:0] {
    ST_ID       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_CAPACITY = 3'd2,
    ST_HEADER   = 3'd3,
    ST_RANGE    = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_PAYLOAD  = 3'd6,
    ST_SIZE     = 3'd7
  } status_e;

  typedef enum logic [4:0] {
    PH_DEGREE = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_CTRL   = 5'b00100,
    PH_DELTA  = 5'b01000,
    PH_TRAIL  = 5'b10000
  } phase_e;

  localparam logic [1:0] CFG_ID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DEG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_POINTS    = 2'd2;
  localparam logic [1:0] CFG_CAPACITY  = 2'd3;

  localparam int unsigned LANES = 4;
  localparam logic [1:0] LANE_MASK = 2'h3;

  typedef struct packed {
    logic [31:0] neighbor_id;
    status_e     status;
    logic        last;
  } result_t;

endpackage

>>> src/svdd_if.sv
// Stream interfaces for encoded bytes and decoded results.
interface svdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_list;
  modport source (output valid, output data_byte, output end_of_list, input ready);
  modport sink (input valid, input data_byte, input end_of_list, output ready);
endinterface

interface svdd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] neighbor_id;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, output neighbor_id, output status, output last, input ready);
  modport sink (input valid, input neighbor_id, input status, input last, output ready);
endinterface

>>> src/svdd_front.sv
// Front part: byte parser, control store and result generation.
module svdd_front #(
  parameter int unsigned DEGREE_LIMIT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              acc_i,
  input  logic [7:0]        byte_i,
  input  logic              eol_i,
  output logic              res_valid_o,
  output svdd_pkg::result_t res_o
);

  localparam int unsigned CTRL_DEPTH = (DEGREE_LIMIT + 2) / svdd_pkg::LANES;
  localparam int unsigned CTRL_AW = (CTRL_DEPTH > 1) ? $clog2(CTRL_DEPTH) : 1;
  localparam int unsigned CL_W = CTRL_AW + 1;
  localparam logic [16:0] MAX_DEG_W = 17'(DEGREE_LIMIT);

  logic [2:0]  iw_q;
  logic [1:0]  dw_q;
  logic [31:0] pc_q;
  logic [8:0]  cap_q;

  svdd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  bif_q, bif_d;
  logic [15:0] deg_q, deg_d;
  logic [15:0] ids_q, ids_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] asm_q, asm_d;
  logic [CL_W-1:0] cl_q, cl_d;
  logic [CTRL_AW-1:0] grp_q, grp_d;
  logic [1:0]  lane_q, lane_d;
  logic        drop_q, drop_d;
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  rd_q;
  logic [7:0]  mem [CTRL_DEPTH];
  logic        mem_we;

  logic [2:0]  eff_iw;
  logic [2:0]  eff_dw;
  logic [16:0] eff_cap;
  logic [31:0] asm_n;
  logic [14:0] ctrl_cnt;
  logic [7:0]  lane_bits;
  logic [2:0]  len;
  logic [32:0] sum;
  logic [15:0] ids_n;
  logic        fail_en, hdr_en, emit_en, restart;
  svdd_pkg::status_e fail_code;
  logic [31:0] hdr_id, emit_id;
  logic [15:0] emit_ids;

  assign eff_iw = (iw_q == 3'd0) ? 3'd1 : ((iw_q > 3'd4) ? 3'd4 : iw_q);
  assign eff_dw = (dw_q < 2'd2) ? 3'd1 : 3'd2;
  assign eff_cap = ({8'd0, cap_q} > MAX_DEG_W) ? MAX_DEG_W : {8'd0, cap_q};
  assign asm_n = asm_q | (32'(byte_i) << {bif_q, 3'b000});
  assign ctrl_cnt = 15'(({1'b0, deg_q} + 17'd2) >> 2);
  assign lane_bits = cur_q >> {lane_q, 1'b0};
  assign len = {1'b0, lane_bits[1:0] & svdd_pkg::LANE_MASK} + 3'd1;
  assign sum = {1'b0, prev_q} + {1'b0, asm_n};
  assign ids_n = ids_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    bif_d = bif_q;
    deg_d = deg_q;
    ids_d = ids_q;
    prev_d = prev_q;
    asm_d = asm_q;
    cl_d = cl_q;
    grp_d = grp_q;
    lane_d = lane_q;
    drop_d = drop_q;
    cur_d = cur_q;
    mem_we = 1'b0;
    res_valid_o = 1'b0;
    res_o = '{neighbor_id: 32'd0, status: svdd_pkg::ST_ID, last: 1'b0};
    fail_en = 1'b0;
    fail_code = svdd_pkg::ST_ID;
    hdr_en = 1'b0;
    hdr_id = 32'd0;
    emit_en = 1'b0;
    emit_id = 32'd0;
    emit_ids = 16'd0;
    restart = 1'b0;
    if (acc_i) begin
      if (drop_q) begin
        if (eol_i) begin
          drop_d = 1'b0;
          restart = 1'b1;
        end
      end else begin
        unique case (phase_q)
          svdd_pkg::PH_DEGREE: begin
            if ({1'b0, bif_q} + 3'd1 < eff_dw) begin
              bif_d = bif_q + 2'd1;
              asm_d = asm_n;
              if (eol_i) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_HEADER;
              end
            end else begin
              deg_d = asm_n[15:0];
              bif_d = 2'd0;
              asm_d = 32'd0;
              if ({1'b0, asm_n[15:0]} > eff_cap) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_CAPACITY;
              end else if (asm_n[15:0] == 16'd0) begin
                if (!eol_i) begin
                  fail_en = 1'b1;
                  fail_code = svdd_pkg::ST_SIZE;
                end else begin
                  restart = 1'b1;
                  res_valid_o = 1'b1;
                  res_o = '{neighbor_id: 32'd0, status: svdd_pkg::ST_EMPTY, last: 1'b1};
                end
              end else if (eol_i) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_HEADER;
              end else begin
                phase_d = svdd_pkg::PH_FIRST;
              end
            end
          end
          svdd_pkg::PH_FIRST: begin
            if ({1'b0, bif_q} + 3'd1 < eff_iw) begin
              bif_d = bif_q + 2'd1;
              asm_d = asm_n;
              if (eol_i) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_HEADER;
              end
            end else begin
              prev_d = asm_n;
              bif_d = 2'd0;
              asm_d = 32'd0;
              if (ctrl_cnt == 15'd0) begin
                hdr_en = 1'b1;
                hdr_id = asm_n;
              end else if (eol_i) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_HEADER;
              end else begin
                phase_d = svdd_pkg::PH_CTRL;
              end
            end
          end
          svdd_pkg::PH_CTRL: begin
            mem_we = 1'b1;
            if (cl_q == '0) begin
              cur_d = byte_i;
            end
            cl_d = cl_q + 1'b1;
            if (15'(cl_q + 1'b1) >= ctrl_cnt) begin
              hdr_en = 1'b1;
              hdr_id = prev_q;
            end else if (eol_i) begin
              fail_en = 1'b1;
              fail_code = svdd_pkg::ST_HEADER;
            end
          end
          svdd_pkg::PH_DELTA: begin
            if ({1'b0, bif_q} + 3'd1 < len) begin
              bif_d = bif_q + 2'd1;
              asm_d = asm_n;
              if (eol_i) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_PAYLOAD;
              end
            end else begin
              bif_d = 2'd0;
              asm_d = 32'd0;
              if (sum[32]) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_OVERFLOW;
              end else if (sum[31:0] >= pc_q) begin
                fail_en = 1'b1;
                fail_code = svdd_pkg::ST_RANGE;
              end else begin
                prev_d = sum[31:0];
                ids_d = ids_n;
                lane_d = lane_q + 2'd1;
                if (lane_q == 2'd3) begin
                  grp_d = grp_q + 1'b1;
                  cur_d = rd_q;
                end
                emit_en = 1'b1;
                emit_id = sum[31:0];
                emit_ids = ids_n;
              end
            end
          end
          svdd_pkg::PH_TRAIL: begin
            fail_en = 1'b1;
            fail_code = svdd_pkg::ST_SIZE;
          end
          default: begin
            fail_en = 1'b1;
            fail_code = svdd_pkg::ST_SIZE;
          end
        endcase
      end
    end
    if (hdr_en) begin
      if (hdr_id >= pc_q) begin
        fail_en = 1'b1;
        fail_code = svdd_pkg::ST_RANGE;
      end else begin
        ids_d = 16'd1;
        lane_d = 2'd0;
        grp_d = '0;
        emit_en = 1'b1;
        emit_id = hdr_id;
        emit_ids = 16'd1;
      end
    end
    if (emit_en) begin
      if (emit_ids >= deg_q) begin
        res_valid_o = 1'b1;
        res_o = '{neighbor_id: emit_id, status: svdd_pkg::ST_ID, last: eol_i};
        if (eol_i) begin
          restart = 1'b1;
        end else begin
          phase_d = svdd_pkg::PH_TRAIL;
        end
      end else if (eol_i) begin
        fail_en = 1'b1;
        fail_code = svdd_pkg::ST_PAYLOAD;
      end else begin
        phase_d = svdd_pkg::PH_DELTA;
        res_valid_o = 1'b1;
        res_o = '{neighbor_id: emit_id, status: svdd_pkg::ST_ID, last: 1'b0};
      end
    end
    if (fail_en) begin
      restart = 1'b1;
      drop_d = !eol_i;
      res_valid_o = 1'b1;
      res_o = '{neighbor_id: 32'd0, status: fail_code, last: 1'b1};
    end
    if (restart) begin
      phase_d = svdd_pkg::PH_DEGREE;
      bif_d = 2'd0;
      deg_d = 16'd0;
      ids_d = 16'd0;
      prev_d = 32'd0;
      asm_d = 32'd0;
      cl_d = '0;
      grp_d = '0;
      lane_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= 3'd4;
      dw_q <= 2'd2;
      pc_q <= 32'hFFFF_FFFF;
      cap_q <= 9'd256;
      phase_q <= svdd_pkg::PH_DEGREE;
      bif_q <= 2'd0;
      deg_q <= 16'd0;
      ids_q <= 16'd0;
      prev_q <= 32'd0;
      asm_q <= 32'd0;
      cl_q <= '0;
      grp_q <= '0;
      lane_q <= 2'd0;
      drop_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          svdd_pkg::CFG_ID_WIDTH:  iw_q <= cfg_data_i[2:0];
          svdd_pkg::CFG_DEG_WIDTH: dw_q <= cfg_data_i[1:0];
          svdd_pkg::CFG_POINTS:    pc_q <= cfg_data_i;
          svdd_pkg::CFG_CAPACITY:  cap_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      phase_q <= phase_d;
      bif_q <= bif_d;
      deg_q <= deg_d;
      ids_q <= ids_d;
      prev_q <= prev_d;
      asm_q <= asm_d;
      cl_q <= cl_d;
      grp_q <= grp_d;
      lane_q <= lane_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cl_q[CTRL_AW-1:0]] <= byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[CTRL_AW'(grp_q + 1'b1)];
  end

endmodule

>>> src/svdd_fifo.sv
// Two-entry result queue between the front and back parts.
module svdd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  svdd_pkg::result_t data_i,
  input  logic              pop_i,
  output svdd_pkg::result_t data_o,
  output logic              empty_o,
  output logic              full_o
);

  svdd_pkg::result_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  assign data_o = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o = (cnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> src/svdd_back.sv
// Back part: output register that delivers results to the sink.
module svdd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  svdd_pkg::result_t data_i,
  output logic              pop_o,
  svdd_out_if.source        out_o
);

  logic              valid_q;
  svdd_pkg::result_t res_q;

  assign pop_o = !empty_i && (!valid_q || out_o.ready);
  assign out_o.valid = valid_q;
  assign out_o.neighbor_id = res_q.neighbor_id;
  assign out_o.status = res_q.status;
  assign out_o.last = res_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= data_i;
    end
  end

endmodule

>>> src/stream_vbyte_delta_decoder.sv
// A result enters the queue as the byte that completes it is taken, then the output register.
// One byte per cycle while the queue has room, set by per-byte assembly, sum and range check.
// Results wait in a two-entry queue and output register, so input runs until the queue fills.
// Reset clears control state except the current control byte and sets configuration defaults.
// The control byte store is not cleared; only entries written for the current list are read.
module stream_vbyte_delta_decoder #(
  parameter int unsigned DEGREE_LIMIT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  svdd_in_if.sink     in_i,
  svdd_out_if.source  out_o
);

  logic              acc;
  logic              res_valid;
  svdd_pkg::result_t res;
  svdd_pkg::result_t head;
  logic              empty, full, pop;

  assign in_i.ready = !full;
  assign acc = in_i.valid && !full;

  svdd_front #(.DEGREE_LIMIT(DEGREE_LIMIT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .byte_i      (in_i.data_byte),
    .eol_i       (in_i.end_of_list),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  svdd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  svdd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> src/svdd_checker.sv
// Port-level assertions for the decoder and their bind statement.
`include "assert_macros.svh"

module svdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_id_i,
  input logic [2:0]  out_status_i,
  input logic        out_last_i
);

  `SVDD_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_id_i))
  `SVDD_ASSERT(a_err_last, !out_valid_i || out_status_i == svdd_pkg::ST_ID || out_last_i)
  `SVDD_ASSERT(a_err_zero, !out_valid_i || out_status_i == svdd_pkg::ST_ID || out_id_i == 32'd0)

endmodule

bind stream_vbyte_delta_decoder svdd_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_id_i     (out_o.neighbor_id),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);
